@@ hdl/nmcp_pkg.sv @@
package nmcp_pkg;

   // Default sizes of the pipe bank.
   localparam int PIPE_COUNT_DEF = 4;
   localparam int RING_DEPTH_DEF = 256;
   localparam int NAME_BYTES_DEF = 15;

   // Fixed widths of the stream fields.
   localparam int NAME_MAX      = 15;
   localparam int CAP_W         = 9;
   localparam int REF_W         = 8;
   localparam int REQ_DATA_W    = 136;
   localparam int RSP_DATA_W    = 16;
   localparam int CAP_RESET     = 256;

   typedef enum logic [2:0] {
      ACT_OPEN  = 3'd0,
      ACT_CLOSE = 3'd1,
      ACT_READ  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_QUERY = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADNAME  = 3'd1,
      ST_NOFREE   = 3'd2,
      ST_MODE     = 3'd3,
      ST_WAIT     = 3'd4,
      ST_EOF      = 3'd5,
      ST_NOREADER = 3'd6
   } status_type;

endpackage

@@ hdl/named_multi_channel_pipe_fifo_top.sv @@
// A result beat appears in the cycle after its request beat is taken. One request
// beat is taken per cycle while result beats are taken; every action, including
// the name match over all pipes and the ring memory access, completes in one pass.
// Reset (synchronous, active high) frees every pipe, clears counts and
// positions and sets the capacity to 256; ring contents are not cleared.
module named_multi_channel_pipe_fifo_top
   import nmcp_pkg::*;
#(
   parameter int PIPE_COUNT = PIPE_COUNT_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: pipe_index[1:0], want_read[2], want_write[3], name_low[67:4],
   //        name_high[123:68], data_in[131:124], zero fill to 136 bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action[2:0]
   input  logic [2:0]            req_tuser,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: opened_index[1:0], data_out[9:2], ready_res[10], zero fill to 16 bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]            rsp_tuser,
   // Capacity register write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_data
);

   localparam int SW   = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
   localparam int PW   = $clog2(RING_DEPTH);
   localparam int FW   = $clog2(RING_DEPTH + 1);
   localparam int CW0  = (FW > CAP_W) ? FW : CAP_W;
   localparam int CMPW = (CW0 > PW + 1) ? CW0 : PW + 1;
   localparam int AW   = SW + PW;

   // Request field split.
   logic [1:0]   pipe_index;
   logic         want_read;
   logic         want_write;
   logic [63:0]  name_low;
   logic [55:0]  name_high;
   logic [7:0]   data_in;
   logic         accept;

   assign pipe_index = req_tdata[1:0];
   assign want_read  = req_tdata[2];
   assign want_write = req_tdata[3];
   assign name_low   = req_tdata[67:4];
   assign name_high  = req_tdata[123:68];
   assign data_in    = req_tdata[131:124];

   // Per-pipe state.
   logic              used_ff   [PIPE_COUNT];
   logic              used_in   [PIPE_COUNT];
   logic [63:0]       nlo_ff    [PIPE_COUNT];
   logic [63:0]       nlo_in    [PIPE_COUNT];
   logic [55:0]       nhi_ff    [PIPE_COUNT];
   logic [55:0]       nhi_in    [PIPE_COUNT];
   logic [PW-1:0]     rpos_ff   [PIPE_COUNT];
   logic [PW-1:0]     rpos_in   [PIPE_COUNT];
   logic [PW-1:0]     wpos_ff   [PIPE_COUNT];
   logic [PW-1:0]     wpos_in   [PIPE_COUNT];
   logic [FW-1:0]     fill_ff   [PIPE_COUNT];
   logic [FW-1:0]     fill_in   [PIPE_COUNT];
   logic [REF_W-1:0]  rref_ff   [PIPE_COUNT];
   logic [REF_W-1:0]  rref_in   [PIPE_COUNT];
   logic [REF_W-1:0]  wref_ff   [PIPE_COUNT];
   logic [REF_W-1:0]  wref_in   [PIPE_COUNT];
   logic              seen_ff   [PIPE_COUNT];
   logic              seen_in   [PIPE_COUNT];

   logic [CAP_W-1:0]  cap_ff;
   logic [CMPW-1:0]   eff_cap;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   status_type        status_in;
   logic [1:0]        opened_ff;
   logic [1:0]        opened_in;
   logic              ready_res_ff;
   logic              ready_res_in;
   logic              rd_ok_ff;
   logic              rd_ok_in;
   logic [7:0]        mem_q_ff;

   // Ring memory.
   logic [7:0]        ring_mem [2**AW];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;

   // Name handling.
   logic [7:0]        nbyte   [NAME_MAX];
   logic [63:0]       norm_lo;
   logic [55:0]       norm_hi;
   logic              name_ok;

   // Handshakes: the result register frees as it is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Clamp the capacity into one ring; a zero capacity counts as one.
   always_comb begin
      eff_cap = CMPW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMPW'(1);
      end
      if (eff_cap > CMPW'(RING_DEPTH)) begin
         eff_cap = CMPW'(RING_DEPTH);
      end
   end

   // Cut the name at its first zero byte and check it.
   always_comb begin
      logic ended;
      logic [7:0] v;
      ended   = 1'b0;
      name_ok = 1'b1;
      for (int i = 0; i < NAME_MAX; i++) begin
         v = (i < 8) ? name_low[8*i +: 8] : name_high[8*(i-8) +: 8];
         if (v == 8'd0) begin
            ended = 1'b1;
         end
         if (ended) begin
            v = 8'd0;
         end
         if (v != 8'd0 && i >= NAME_BYTES) begin
            name_ok = 1'b0;
         end
         nbyte[i] = v;
      end
      if (nbyte[0] == 8'd0) begin
         name_ok = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
         norm_lo[8*i +: 8] = nbyte[i];
      end
      for (int i = 0; i < 7; i++) begin
         norm_hi[8*i +: 8] = nbyte[i+8];
      end
   end

   // Action decode and next state.
   always_comb begin
      logic [SW-1:0]   t;
      logic            live;
      logic            hit;
      logic            claim;
      logic [SW-1:0]   hs;
      logic [CMPW-1:0] nxt;
      for (int s = 0; s < PIPE_COUNT; s++) begin
         used_in[s] = used_ff[s];
         nlo_in[s]  = nlo_ff[s];
         nhi_in[s]  = nhi_ff[s];
         rpos_in[s] = rpos_ff[s];
         wpos_in[s] = wpos_ff[s];
         fill_in[s] = fill_ff[s];
         rref_in[s] = rref_ff[s];
         wref_in[s] = wref_ff[s];
         seen_in[s] = seen_ff[s];
      end
      t            = SW'(pipe_index);
      live         = (int'(pipe_index) < PIPE_COUNT) && used_ff[t];
      hit          = 1'b0;
      claim        = 1'b0;
      hs           = '0;
      nxt          = '0;
      status_in    = ST_OK;
      opened_in    = 2'd0;
      ready_res_in = 1'b0;
      rd_ok_in     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {t, wpos_ff[t]};
      mem_raddr    = {t, rpos_ff[t]};

      // Name match first, then the first free pipe.
      for (int s = 0; s < PIPE_COUNT; s++) begin
         if (!hit && used_ff[s] && nlo_ff[s] == norm_lo && nhi_ff[s] == norm_hi) begin
            hit = 1'b1;
            hs  = SW'(s);
         end
      end
      for (int s = 0; s < PIPE_COUNT; s++) begin
         if (!hit && !used_ff[s]) begin
            hit   = 1'b1;
            claim = 1'b1;
            hs    = SW'(s);
         end
      end

      case (req_tuser)
         ACT_OPEN: begin
            if (!name_ok) begin
               status_in = ST_BADNAME;
            end else if (!want_read && !want_write) begin
               status_in = ST_MODE;
            end else if (!hit) begin
               status_in = ST_NOFREE;
            end else begin
               if (claim) begin
                  used_in[hs] = 1'b1;
                  nlo_in[hs]  = norm_lo;
                  nhi_in[hs]  = norm_hi;
                  rpos_in[hs] = '0;
                  wpos_in[hs] = '0;
                  fill_in[hs] = '0;
                  rref_in[hs] = '0;
                  wref_in[hs] = '0;
                  seen_in[hs] = 1'b0;
               end
               if (want_read && rref_in[hs] != '1) begin
                  rref_in[hs] = rref_in[hs] + 1'b1;
               end
               if (want_write) begin
                  if (wref_in[hs] != '1) begin
                     wref_in[hs] = wref_in[hs] + 1'b1;
                  end
                  seen_in[hs] = 1'b1;
               end
               opened_in = 2'(hs);
            end
         end
         ACT_CLOSE: begin
            if (live) begin
               if (want_read && rref_ff[t] != '0) begin
                  rref_in[t] = rref_ff[t] - 1'b1;
               end
               if (want_write && wref_ff[t] != '0) begin
                  wref_in[t] = wref_ff[t] - 1'b1;
               end
               if (rref_in[t] == '0 && wref_in[t] == '0) begin
                  used_in[t] = 1'b0;
                  rpos_in[t] = '0;
                  wpos_in[t] = '0;
                  fill_in[t] = '0;
                  seen_in[t] = 1'b0;
               end
            end
         end
         ACT_READ: begin
            if (!live || !want_read) begin
               status_in = ST_MODE;
            end else if (fill_ff[t] != '0) begin
               rd_ok_in   = 1'b1;
               nxt        = CMPW'(rpos_ff[t]) + 1'b1;
               rpos_in[t] = (nxt >= eff_cap) ? '0 : PW'(nxt);
               fill_in[t] = fill_ff[t] - 1'b1;
            end else if (wref_ff[t] == '0 && seen_ff[t]) begin
               status_in = ST_EOF;
            end else begin
               status_in = ST_WAIT;
            end
         end
         ACT_WRITE: begin
            if (!live || !want_write) begin
               status_in = ST_MODE;
            end else if (CMPW'(fill_ff[t]) < eff_cap) begin
               mem_we     = 1'b1;
               nxt        = CMPW'(wpos_ff[t]) + 1'b1;
               wpos_in[t] = (nxt >= eff_cap) ? '0 : PW'(nxt);
               fill_in[t] = fill_ff[t] + 1'b1;
            end else if (rref_ff[t] != '0) begin
               status_in = ST_WAIT;
            end else begin
               status_in = ST_NOREADER;
            end
         end
         ACT_QUERY: begin
            if (live) begin
               ready_res_in = (fill_ff[t] != '0) || (wref_ff[t] == '0 && seen_ff[t]);
            end
         end
         default: begin
            status_in = ST_MODE;
         end
      endcase
   end

   // The result beat stays until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and pipe state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_W'(CAP_RESET);
         for (int s = 0; s < PIPE_COUNT; s++) begin
            used_ff[s] <= 1'b0;
            nlo_ff[s]  <= '0;
            nhi_ff[s]  <= '0;
            rpos_ff[s] <= '0;
            wpos_ff[s] <= '0;
            fill_ff[s] <= '0;
            rref_ff[s] <= '0;
            wref_ff[s] <= '0;
            seen_ff[s] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (accept) begin
            for (int s = 0; s < PIPE_COUNT; s++) begin
               used_ff[s] <= used_in[s];
               nlo_ff[s]  <= nlo_in[s];
               nhi_ff[s]  <= nhi_in[s];
               rpos_ff[s] <= rpos_in[s];
               wpos_ff[s] <= wpos_in[s];
               fill_ff[s] <= fill_in[s];
               rref_ff[s] <= rref_in[s];
               wref_ff[s] <= wref_in[s];
               seen_ff[s] <= seen_in[s];
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         opened_ff    <= opened_in;
         ready_res_ff <= ready_res_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   // Ring memory: at most one write and one registered read per beat.
   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         ring_mem[mem_waddr] <= data_in;
      end
      if (accept) begin
         mem_q_ff <= ring_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, ready_res_ff, (rd_ok_ff ? mem_q_ff : 8'd0), opened_ff};

`ifndef SYNTHESIS
   // A free pipe holds no endpoints and no data.
   for (genvar g = 0; g < PIPE_COUNT; g++) begin : g_free_chk
      a_free_empty: assert property (@(posedge clock) disable iff (reset)
         !used_ff[g] |-> (rref_ff[g] == '0 && wref_ff[g] == '0 && fill_ff[g] == '0))
         else $error("free pipe %0d holds counts or data", g);
      a_fill_bound: assert property (@(posedge clock) disable iff (reset)
         fill_ff[g] <= FW'(RING_DEPTH))
         else $error("pipe %0d fill level beyond ring depth", g);
   end

   // Only a successful read returns a byte.
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> (rsp_tdata[9:2] == 8'd0 && !rd_ok_ff))
      else $error("byte returned with a failing status");

   // A taken request always leaves a result beat behind.
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result beat");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result beat pending after reset");
`endif

endmodule
